>>> rtl/mandelbrot_escape_time_pixel_core_macros.svh
// Assertion macros shared by the escape-time pixel core.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mbe_pkg.sv
// Types, constants and helper functions for the escape-time pixel core.
// No dependencies; every other RTL module imports this package.
package mbe_pkg;

  // Fixed-point format: 32-bit signed words with FRAC_BITS fraction bits.
  localparam int FRAC_BITS = 28;
  localparam int WORD_W    = 32;
  localparam int STEP_W    = 31;
  localparam int PROD_W    = 64;
  // Wide signed width for sums before saturation.
  localparam int WIDE_W    = 66;

  // Register port geometry.
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;

  // Escape threshold |z|^2 >= 4.
  localparam logic [PROD_W:0] ESCAPE_LIM = (PROD_W + 1)'(4) << FRAC_BITS;

  // Colour increment per iteration.
  localparam logic [WORD_W-1:0] COLOUR_STEP = 32'd1835750;

  // Register reset values.
  localparam logic signed [WORD_W-1:0] ORIGIN_REAL_RST = -32'sd563714458;
  localparam logic signed [WORD_W-1:0] ORIGIN_IMAG_RST = -32'sd322122547;
  localparam logic [STEP_W-1:0]        PIXEL_STEP_RST  = 31'd1073742;
  localparam int                       ITER_LIMIT_RST  = 90;

  // Register indexes.
  typedef enum logic [1:0] {
    REG_ORIGIN_REAL = 2'd0,
    REG_ORIGIN_IMAG = 2'd1,
    REG_PIXEL_STEP  = 2'd2,
    REG_ITER_LIMIT  = 2'd3
  } reg_idx_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_C_MUL,
    ST_C_ADD,
    ST_IT_MUL,
    ST_IT_UPD,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic c_mul;
    logic c_add;
    logic it_mul;
    logic it_upd;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic limit_hit;
    logic escaped;
  } status_t;

  // Saturate a wide signed value to the signed word range.
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-WORD_W:0] hi;
    hi = v[WIDE_W-1:WORD_W-1];
    if ((&hi) || (~|hi)) begin
      sat_word = v[WORD_W-1:0];
    end else if (v[WIDE_W-1]) begin
      sat_word = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      sat_word = {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

  // Magnitude of a signed word; the most negative value maps to 2^31.
  function automatic logic [WORD_W-1:0] mag_word(input logic signed [WORD_W-1:0] v);
    mag_word = v[WORD_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

>>> rtl/mbe_regs.sv
// Configuration register file behind the APB-style port.
// Depends on mbe_pkg for the register map and reset values.
module mbe_regs import mbe_pkg::*; #(
  parameter int ITER_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  output logic signed [WORD_W-1:0] origin_real,
  output logic signed [WORD_W-1:0] origin_imag,
  output logic [STEP_W-1:0]        pixel_step,
  output logic [ITER_BITS-1:0]     iteration_limit
);

  logic signed [WORD_W-1:0] origin_real_r, origin_real_nxt;
  logic signed [WORD_W-1:0] origin_imag_r, origin_imag_nxt;
  logic [STEP_W-1:0]        pixel_step_r, pixel_step_nxt;
  logic [ITER_BITS-1:0]     iter_limit_r, iter_limit_nxt;
  logic                     wr_en;
  reg_idx_t                 idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  // Write decode: a beat updates the addressed register only.
  always_comb begin
    origin_real_nxt = origin_real_r;
    origin_imag_nxt = origin_imag_r;
    pixel_step_nxt  = pixel_step_r;
    iter_limit_nxt  = iter_limit_r;
    if (wr_en) begin
      case (idx)
        REG_ORIGIN_REAL: origin_real_nxt = pwdata[WORD_W-1:0];
        REG_ORIGIN_IMAG: origin_imag_nxt = pwdata[WORD_W-1:0];
        REG_PIXEL_STEP:  pixel_step_nxt  = pwdata[STEP_W-1:0];
        REG_ITER_LIMIT:  iter_limit_nxt  = pwdata[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_real_r <= ORIGIN_REAL_RST;
      origin_imag_r <= ORIGIN_IMAG_RST;
      pixel_step_r  <= PIXEL_STEP_RST;
      iter_limit_r  <= ITER_BITS'(ITER_LIMIT_RST);
    end else begin
      origin_real_r <= origin_real_nxt;
      origin_imag_r <= origin_imag_nxt;
      pixel_step_r  <= pixel_step_nxt;
      iter_limit_r  <= iter_limit_nxt;
    end
  end

  // Read back the addressed register, zero-extended.
  always_comb begin
    case (idx)
      REG_ORIGIN_REAL: prdata = origin_real_r;
      REG_ORIGIN_IMAG: prdata = origin_imag_r;
      REG_PIXEL_STEP:  prdata = DATA_W'(pixel_step_r);
      REG_ITER_LIMIT:  prdata = DATA_W'(iter_limit_r);
      default:         prdata = '0;
    endcase
  end

  assign origin_real     = origin_real_r;
  assign origin_imag     = origin_imag_r;
  assign pixel_step      = pixel_step_r;
  assign iteration_limit = iter_limit_r;

endmodule

>>> rtl/mbe_dp.sv
// Datapath: point set-up, square-and-add iteration and the result register.
// Depends on mbe_pkg; driven by mbe_ctrl through cmd_t and status_t.
module mbe_dp import mbe_pkg::*; #(
  parameter int COORD_BITS = 11,
  parameter int ITER_BITS  = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output status_t                  sts,
  input  logic [COORD_BITS-1:0]    in_pixel_x,
  input  logic [COORD_BITS-1:0]    in_pixel_y,
  input  logic signed [WORD_W-1:0] origin_real,
  input  logic signed [WORD_W-1:0] origin_imag,
  input  logic [STEP_W-1:0]        pixel_step,
  input  logic [ITER_BITS-1:0]     iteration_limit,
  output logic [COORD_BITS-1:0]    out_x,
  output logic [COORD_BITS-1:0]    out_y,
  output logic [ITER_BITS-1:0]     out_iteration_count,
  output logic                     out_inside_set,
  output logic [WORD_W-1:0]        out_colour
);

  localparam int CP_W = COORD_BITS + STEP_W;

  // Working registers.
  logic [COORD_BITS-1:0]    px_r, px_nxt, py_r, py_nxt;
  logic [CP_W-1:0]          cp_re_r, cp_re_nxt, cp_im_r, cp_im_nxt;
  logic signed [WORD_W-1:0] cr_r, cr_nxt, ci_r, ci_nxt;
  logic signed [WORD_W-1:0] zr_r, zr_nxt, zi_r, zi_nxt;
  logic [PROD_W-1:0]        prr_r, prr_nxt, pii_r, pii_nxt, pri_r, pri_nxt;
  logic [ITER_BITS-1:0]     cnt_r, cnt_nxt;
  logic [WORD_W-1:0]        colour_r, colour_nxt;

  // Result register.
  logic [COORD_BITS-1:0]    ox_r, ox_nxt, oy_r, oy_nxt;
  logic [ITER_BITS-1:0]     ocnt_r, ocnt_nxt;
  logic                     oin_r, oin_nxt;
  logic [WORD_W-1:0]        ocol_r, ocol_nxt;

  // Combinational terms.
  logic [WORD_W-1:0]        ar, ai;
  logic [PROD_W-1:0]        sr, si, cross_term;
  logic [PROD_W:0]          sum_sq;
  logic signed [WIDE_W-1:0] cr_sum, ci_sum, zr_sum, cs, zi_sum;

  assign ar = mag_word(zr_r);
  assign ai = mag_word(zi_r);

  // Squares and cross term from the registered products.
  assign sr         = prr_r >> FRAC_BITS;
  assign si         = pii_r >> FRAC_BITS;
  assign cross_term = pri_r >> (FRAC_BITS - 1);
  assign sum_sq     = {1'b0, sr} + {1'b0, si};

  // Point set-up sums: origin plus pixel offset.
  assign cr_sum = WIDE_W'(origin_real) + $signed(WIDE_W'(cp_re_r));
  assign ci_sum = WIDE_W'(origin_imag) + $signed(WIDE_W'(cp_im_r));

  // New z; the cross term takes the sign of zr * zi, truncated toward zero.
  assign zr_sum = $signed(WIDE_W'(sr)) - $signed(WIDE_W'(si)) + WIDE_W'(cr_r);
  assign cs     = (zr_r[WORD_W-1] ^ zi_r[WORD_W-1]) ? -$signed(WIDE_W'(cross_term))
                                                    :  $signed(WIDE_W'(cross_term));
  assign zi_sum = cs + WIDE_W'(ci_r);

  assign sts.limit_hit = (cnt_r >= iteration_limit);
  assign sts.escaped   = (sum_sq >= ESCAPE_LIM);

  // Next-state logic for the working registers.
  always_comb begin
    px_nxt     = px_r;
    py_nxt     = py_r;
    cp_re_nxt  = cp_re_r;
    cp_im_nxt  = cp_im_r;
    cr_nxt     = cr_r;
    ci_nxt     = ci_r;
    zr_nxt     = zr_r;
    zi_nxt     = zi_r;
    prr_nxt    = prr_r;
    pii_nxt    = pii_r;
    pri_nxt    = pri_r;
    cnt_nxt    = cnt_r;
    colour_nxt = colour_r;
    if (cmd.start) begin
      px_nxt     = in_pixel_x;
      py_nxt     = in_pixel_y;
      zr_nxt     = '0;
      zi_nxt     = '0;
      cnt_nxt    = '0;
      colour_nxt = '0;
    end
    if (cmd.c_mul) begin
      cp_re_nxt = CP_W'(px_r) * CP_W'(pixel_step);
      cp_im_nxt = CP_W'(py_r) * CP_W'(pixel_step);
    end
    if (cmd.c_add) begin
      cr_nxt = sat_word(cr_sum);
      ci_nxt = sat_word(ci_sum);
    end
    if (cmd.it_mul) begin
      prr_nxt = PROD_W'(ar) * PROD_W'(ar);
      pii_nxt = PROD_W'(ai) * PROD_W'(ai);
      pri_nxt = PROD_W'(ar) * PROD_W'(ai);
    end
    if (cmd.it_upd) begin
      zr_nxt     = sat_word(zr_sum);
      zi_nxt     = sat_word(zi_sum);
      cnt_nxt    = cnt_r + 1'b1;
      colour_nxt = colour_r + COLOUR_STEP;
    end
  end

  // Next-state logic for the result register.
  always_comb begin
    ox_nxt   = ox_r;
    oy_nxt   = oy_r;
    ocnt_nxt = ocnt_r;
    oin_nxt  = oin_r;
    ocol_nxt = ocol_r;
    if (cmd.out_load) begin
      ox_nxt   = px_r;
      oy_nxt   = py_r;
      ocnt_nxt = cnt_r;
      oin_nxt  = sts.limit_hit;
      ocol_nxt = sts.limit_hit ? '0 : colour_r;
    end
  end

  // The count feeds a status compare, so it is cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    cp_re_r  <= cp_re_nxt;
    cp_im_r  <= cp_im_nxt;
    cr_r     <= cr_nxt;
    ci_r     <= ci_nxt;
    zr_r     <= zr_nxt;
    zi_r     <= zi_nxt;
    prr_r    <= prr_nxt;
    pii_r    <= pii_nxt;
    pri_r    <= pri_nxt;
    colour_r <= colour_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    ocnt_r   <= ocnt_nxt;
    oin_r    <= oin_nxt;
    ocol_r   <= ocol_nxt;
  end

  assign out_x               = ox_r;
  assign out_y               = oy_r;
  assign out_iteration_count = ocnt_r;
  assign out_inside_set      = oin_r;
  assign out_colour          = ocol_r;

endmodule

>>> rtl/mbe_ctrl.sv
// Controller: sequences set-up and iterations and owns both handshakes.
// Depends on mbe_pkg and the assertion macros header.
`include "mandelbrot_escape_time_pixel_core_macros.svh"

module mbe_ctrl import mbe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The result register can take a new beat when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_C_MUL;
        end
      end
      ST_C_MUL: begin
        cmd.c_mul = 1'b1;
        state_nxt = ST_C_ADD;
      end
      ST_C_ADD: begin
        cmd.c_add = 1'b1;
        state_nxt = ST_IT_MUL;
      end
      ST_IT_MUL: begin
        if (sts.limit_hit) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.it_mul = 1'b1;
          state_nxt  = ST_IT_UPD;
        end
      end
      ST_IT_UPD: begin
        if (sts.escaped) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.it_upd = 1'b1;
          state_nxt  = ST_IT_MUL;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid follows loads and completed beats.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  `MBE_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_r == ST_C_MUL, "accepted pixel did not start set-up")
  `MBE_ASSERT_NEXT(a_limit_ends, state_r == ST_IT_MUL && sts.limit_hit, state_r == ST_FINISH, "limit reached but iteration continued")
  `MBE_ASSERT_NEXT(a_bounded_loops, state_r == ST_IT_UPD && !sts.escaped, state_r == ST_IT_MUL, "unescaped point left the loop")
  `MBE_ASSERT_NEXT(a_finish_delivers, state_r == ST_FINISH && out_free, out_valid_r && state_r == ST_IDLE, "finished pixel not delivered")

endmodule

>>> rtl/mandelbrot_escape_time_pixel_core.sv
// Escape-time pixel core: maps a pixel to c and iterates z = z^2 + c.
// An input beat passes through the C_MUL and C_ADD set-up states, then the
// IT_MUL/IT_UPD square-and-add loop and FINISH before the result is loaded.
// A new pixel is taken in the cycle after the previous result is loaded, so
// one pixel is in flight at a time; the square-and-add loop sets the pixel rate.
// Synchronous active-low reset restores the default view and empties the core.
module mandelbrot_escape_time_pixel_core import mbe_pkg::*; #(
  parameter int COORD_BITS = 11,
  parameter int ITER_BITS  = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_pixel_x,
  input  logic [COORD_BITS-1:0] in_pixel_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic [ITER_BITS-1:0]  out_iteration_count,
  output logic                  out_inside_set,
  output logic [WORD_W-1:0]     out_colour,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  logic signed [WORD_W-1:0] origin_real;
  logic signed [WORD_W-1:0] origin_imag;
  logic [STEP_W-1:0]        pixel_step;
  logic [ITER_BITS-1:0]     iteration_limit;
  cmd_t                     cmd;
  status_t                  sts;

  // Configuration registers.
  mbe_regs #(
    .ITER_BITS(ITER_BITS)
  ) u_regs (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .origin_real     (origin_real),
    .origin_imag     (origin_imag),
    .pixel_step      (pixel_step),
    .iteration_limit (iteration_limit)
  );

  // Sequencing and handshakes.
  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and result register.
  mbe_dp #(
    .COORD_BITS(COORD_BITS),
    .ITER_BITS (ITER_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_pixel_x          (in_pixel_x),
    .in_pixel_y          (in_pixel_y),
    .origin_real         (origin_real),
    .origin_imag         (origin_imag),
    .pixel_step          (pixel_step),
    .iteration_limit     (iteration_limit),
    .out_x               (out_x),
    .out_y               (out_y),
    .out_iteration_count (out_iteration_count),
    .out_inside_set      (out_inside_set),
    .out_colour          (out_colour)
  );

endmodule
